// ===== sv/prime_modular_alu_defines.svh =====
`ifndef PRIME_MODULAR_ALU_DEFINES_SVH
`define PRIME_MODULAR_ALU_DEFINES_SVH

// checks that a condition implies another in the same cycle
`define PMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// checks that a condition implies another in the next cycle
`define PMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pma_pkg.sv =====
`default_nettype none

package pma_pkg;

    localparam logic [29:0] MODULUS = 30'd1000000007;
    // floor(2^60 / modulus), barrett reciprocal
    localparam logic [30:0] BARRETT_MU = 31'd1152921496;
    // fermat inverse exponent, modulus minus two
    localparam logic [31:0] INV_EXPONENT = 32'd1000000005;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_POW = 3'd3;
    localparam logic [2:0] CMD_DIV = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [29:0] operand_a;
        logic [29:0] operand_b;
        logic [31:0] exponent;
    } pma_req_t;

    typedef struct packed {
        logic [29:0] result;
        logic        zero_divisor;
    } pma_rsp_t;

    typedef struct packed {
        logic        start;
        logic [29:0] x;
        logic [29:0] y;
    } pma_mm_req_t;

    typedef struct packed {
        logic        done;
        logic [29:0] r;
    } pma_mm_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STEP,
        ST_WAIT_ACC,
        ST_WAIT_SQ,
        ST_WAIT_FIN
    } pma_state_t;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_QUOT,
        MM_QPROD,
        MM_SUB,
        MM_FIX1,
        MM_FIX2
    } pma_mm_state_t;

    function automatic logic [29:0] reduce_once(input logic [29:0] v);
        logic [29:0] r;
        r = v;
        if (v >= MODULUS)
        begin
            r = v - MODULUS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pma_mulmod.sv =====
`default_nettype none

module pma_mulmod (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pma_pkg::pma_mm_req_t mm_req,
    output pma_pkg::pma_mm_rsp_t      mm_rsp
);
    import pma_pkg::*;

    pma_mm_state_t state_reg, state_next;
    logic          done_reg, done_next;

    logic [59:0] t_reg;
    logic [61:0] prod_reg;
    logic [31:0] r_reg;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    // the one shared multiplier: product, quotient estimate, quotient times modulus
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (state_reg)
            MM_IDLE:
            begin
                mul_x = {2'b00, mm_req.x};
                mul_y = {2'b00, mm_req.y};
            end
            MM_QUOT:
            begin
                mul_x = {1'b0, t_reg[59:29]};
                mul_y = {1'b0, BARRETT_MU};
            end
            MM_QPROD:
            begin
                mul_x = {1'b0, prod_reg[61:31]};
                mul_y = {2'b00, MODULUS};
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MM_IDLE:
            begin
                if (mm_req.start)
                begin
                    state_next = MM_QUOT;
                end
            end
            MM_QUOT:  state_next = MM_QPROD;
            MM_QPROD: state_next = MM_SUB;
            MM_SUB:   state_next = MM_FIX1;
            MM_FIX1:  state_next = MM_FIX2;
            MM_FIX2:
            begin
                state_next = MM_IDLE;
                done_next  = 1'b1;
            end
            default:  state_next = MM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            MM_IDLE:
            begin
                if (mm_req.start)
                begin
                    t_reg <= mul_p[59:0];
                end
            end
            MM_QUOT:  prod_reg <= mul_p[61:0];
            MM_QPROD: prod_reg <= mul_p[61:0];
            // true remainder is below three moduli, so 32 bits hold it
            MM_SUB:   r_reg <= t_reg[31:0] - prod_reg[31:0];
            MM_FIX1, MM_FIX2:
            begin
                if (r_reg >= {2'b00, MODULUS})
                begin
                    r_reg <= r_reg - {2'b00, MODULUS};
                end
            end
            default:  r_reg <= r_reg;
        endcase
    end

    assign mm_rsp.done = done_reg;
    assign mm_rsp.r    = r_reg[29:0];

endmodule

`default_nettype wire

// ===== sv/prime_modular_alu.sv =====
`default_nettype none
`include "prime_modular_alu_defines.svh"

// channel   | handshake           | word
// ----------+---------------------+----------------------------------------
// command   | start, busy         | request: cmd, operand_a, operand_b, exponent
// result    | done (one cycle)    | response: result, zero_divisor
//
// add, subtract, unknown command and zero divisor: dispatch sets the registered strobe.
// multiply: a single product on the shared modular multiplier.
// power: one product per set exponent bit, one square per lower bit, at most 63.
// divide: a fixed exponent of 30 bits with 44 products plus one.
// busy is high from accept until the strobe; reset clears the sequencers only.
// the receiver takes each word in the strobe cycle and cannot stall.
module prime_modular_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pma_pkg::pma_req_t request,
    output logic                   done,
    output pma_pkg::pma_rsp_t      response
);
    import pma_pkg::*;

    pma_state_t  state_reg, state_next;
    logic        done_reg, done_next;

    logic [2:0]  cmd_reg, cmd_next;
    logic [29:0] a_reg, a_next;
    logic [29:0] b_reg, b_next;
    logic [29:0] acc_reg, acc_next;
    logic [29:0] sq_reg, sq_next;
    logic [31:0] e_reg, e_next;
    logic [29:0] result_reg, result_next;
    logic        zflag_reg, zflag_next;

    pma_mm_req_t mm_req;
    pma_mm_rsp_t mm_rsp;

    logic [30:0] sum_w;
    logic [30:0] add_res;
    logic [30:0] sub_res;

    pma_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .mm_req (mm_req),
        .mm_rsp (mm_rsp)
    );

    always_comb
    begin
        sum_w   = {1'b0, a_reg} + {1'b0, b_reg};
        add_res = (sum_w >= {1'b0, MODULUS}) ? (sum_w - {1'b0, MODULUS}) : sum_w;
        sub_res = (a_reg >= b_reg) ? ({1'b0, a_reg} - {1'b0, b_reg})
                                   : ({1'b0, a_reg} + {1'b0, MODULUS} - {1'b0, b_reg});
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd_next    = cmd_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        e_next      = e_reg;
        result_next = result_reg;
        zflag_next  = zflag_reg;
        mm_req      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = request.cmd;
                    a_next     = reduce_once(request.operand_a);
                    b_next     = reduce_once(request.operand_b);
                    e_next     = request.exponent;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        result_next = add_res[29:0];
                        zflag_next  = 1'b0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    CMD_SUB:
                    begin
                        result_next = sub_res[29:0];
                        zflag_next  = 1'b0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    CMD_MUL:
                    begin
                        mm_req.start = 1'b1;
                        mm_req.x     = a_reg;
                        mm_req.y     = b_reg;
                        state_next   = ST_WAIT_FIN;
                    end
                    CMD_POW:
                    begin
                        acc_next   = 30'd1;
                        sq_next    = a_reg;
                        state_next = ST_STEP;
                    end
                    CMD_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            result_next = '0;
                            zflag_next  = 1'b1;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            acc_next   = 30'd1;
                            sq_next    = b_reg;
                            e_next     = INV_EXPONENT;
                            state_next = ST_STEP;
                        end
                    end
                    default:
                    begin
                        result_next = '0;
                        zflag_next  = 1'b0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                endcase
            end
            ST_STEP:
            begin
                // exponent exhausted: no further product changes the accumulator
                if (e_reg == '0)
                begin
                    if (cmd_reg == CMD_DIV)
                    begin
                        mm_req.start = 1'b1;
                        mm_req.x     = acc_reg;
                        mm_req.y     = a_reg;
                        state_next   = ST_WAIT_FIN;
                    end
                    else
                    begin
                        result_next = acc_reg;
                        zflag_next  = 1'b0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (e_reg[0])
                begin
                    mm_req.start = 1'b1;
                    mm_req.x     = acc_reg;
                    mm_req.y     = sq_reg;
                    state_next   = ST_WAIT_ACC;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    mm_req.x     = sq_reg;
                    mm_req.y     = sq_reg;
                    state_next   = ST_WAIT_SQ;
                end
            end
            ST_WAIT_ACC:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.r;
                    if (e_reg[31:1] == '0)
                    begin
                        e_next     = '0;
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        mm_req.start = 1'b1;
                        mm_req.x     = sq_reg;
                        mm_req.y     = sq_reg;
                        state_next   = ST_WAIT_SQ;
                    end
                end
            end
            ST_WAIT_SQ:
            begin
                if (mm_rsp.done)
                begin
                    sq_next    = mm_rsp.r;
                    e_next     = {1'b0, e_reg[31:1]};
                    state_next = ST_STEP;
                end
            end
            ST_WAIT_FIN:
            begin
                if (mm_rsp.done)
                begin
                    result_next = mm_rsp.r;
                    zflag_next  = 1'b0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        e_reg      <= e_next;
        result_reg <= result_next;
        zflag_reg  <= zflag_next;
    end

    assign busy                  = (state_reg != ST_IDLE);
    assign done                  = done_reg;
    assign response.result       = result_reg;
    assign response.zero_divisor = zflag_reg;

    `PMA_ASSERT_SAME(a_result_reduced, clk, rst_n, done, response.result < MODULUS, "result word not reduced")
    `PMA_ASSERT_SAME(a_done_not_busy, clk, rst_n, done, !busy, "strobe while still busy")
    `PMA_ASSERT_SAME(a_zdiv_zero, clk, rst_n, done && response.zero_divisor, response.result == '0, "zero divisor with nonzero result")
    `PMA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "accepted command not held busy")
    `PMA_ASSERT_SAME(a_mm_idle_quiet, clk, rst_n, state_reg == ST_IDLE, !mm_rsp.done, "multiplier finished with nothing pending")

endmodule

`default_nettype wire

// ===== test/pma_result_checker.sv =====
module pma_result_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  pma_pkg::pma_req_t request,
    input  logic              done,
    input  pma_pkg::pma_rsp_t response,
    output int                pending,
    output int                mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import pma_pkg::*;

    pma_rsp_t expected_residues[$];
    int       error_count = 0;

    // one conditional subtraction is enough since 2^30 < 2 * modulus
    function automatic logic [29:0] fold_residue(input logic [29:0] v);
        logic [29:0] r;
        r = v;
        if (v >= MODULUS)
        begin
            r = v - MODULUS;
        end
        return r;
    endfunction

    function automatic logic [29:0] mul_residue(input logic [29:0] x, input logic [29:0] y);
        logic [63:0] prod;
        logic [63:0] rem;
        prod = {34'd0, x} * {34'd0, y};
        rem  = prod % {34'd0, MODULUS};
        return rem[29:0];
    endfunction

    // square-and-multiply from the least significant exponent bit
    function automatic logic [29:0] pow_residue(input logic [29:0] base, input logic [31:0] e);
        logic [29:0] acc;
        logic [29:0] sq;
        acc = 30'd1;
        sq  = base;
        for (int i = 0; i < 32; i++)
        begin
            if (e[i])
            begin
                acc = mul_residue(acc, sq);
            end
            sq = mul_residue(sq, sq);
        end
        return acc;
    endfunction

    function automatic pma_rsp_t predict_residue(input pma_req_t w);
        pma_rsp_t    out;
        logic [29:0] a;
        logic [29:0] b;
        logic [30:0] wide;
        a   = fold_residue(w.operand_a);
        b   = fold_residue(w.operand_b);
        out = '0;
        case (w.cmd)
            CMD_ADD:
            begin
                wide = {1'b0, a} + {1'b0, b};
                if (wide >= {1'b0, MODULUS})
                begin
                    wide = wide - {1'b0, MODULUS};
                end
                out.result = wide[29:0];
            end
            CMD_SUB:
            begin
                if (a >= b)
                begin
                    out.result = a - b;
                end
                else
                begin
                    wide       = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
                    out.result = wide[29:0];
                end
            end
            CMD_MUL:
            begin
                out.result = mul_residue(a, b);
            end
            CMD_POW:
            begin
                out.result = pow_residue(a, w.exponent);
            end
            CMD_DIV:
            begin
                if (b == 30'd0)
                begin
                    out.zero_divisor = 1'b1;
                end
                else
                begin
                    out.result = mul_residue(a, pow_residue(b, INV_EXPONENT));
                end
            end
            default:
            begin
                out = '0;
            end
        endcase
        return out;
    endfunction

    always @(posedge clk)
    begin
        pma_rsp_t want;
        if (rst_n)
        begin
            // retire the word leaving first, a new command joins at the back
            if (done)
            begin
                if (expected_residues.size() == 0)
                begin
                    $error("result word with nothing expected: result %0d zero_divisor %0b",
                           response.result, response.zero_divisor);
                    error_count++;
                end
                else
                begin
                    want = expected_residues.pop_front();
                    if (response.result !== want.result)
                    begin
                        $error("result: expected %0d, actual %0d",
                               want.result, response.result);
                        error_count++;
                    end
                    if (response.zero_divisor !== want.zero_divisor)
                    begin
                        $error("zero_divisor: expected %0b, actual %0b",
                               want.zero_divisor, response.zero_divisor);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_residues = {expected_residues, predict_residue(request)};
            end
        end
        pending    <= expected_residues.size();
        mismatches <= error_count;
    end

endmodule

// ===== test/tb_prime_modular_alu.sv =====
module tb_prime_modular_alu;
    timeunit 1ns;
    timeprecision 1ps;

    import pma_pkg::*;

    localparam logic [2:0]  CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  CMD_LAST         = 3'd7;
    localparam logic [29:0] RESIDUE_MAX      = MODULUS - 30'd1;
    localparam logic [29:0] OPERAND_MAX      = 30'h3FFF_FFFF;
    localparam int          RANDOM_WORDS     = 450;
    localparam int          STEADY_TAIL      = 60;
    localparam int          SETTLE_CYCLES    = 450;
    localparam int          CYCLE_LIMIT      = 1000000;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    pma_req_t request = '0;
    logic     busy;
    logic     done;
    pma_rsp_t response;
    int       pending;
    int       mismatches;
    int       cycle_count = 0;

    pma_req_t directed_words[$];

    prime_modular_alu dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    pma_result_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .response   (response),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic pma_req_t make_word(input logic [2:0] cmd, input logic [29:0] a,
                                           input logic [29:0] b, input logic [31:0] e);
        pma_req_t w;
        w.cmd       = cmd;
        w.operand_a = a;
        w.operand_b = b;
        w.exponent  = e;
        return w;
    endfunction

    task automatic queue_directed(input pma_req_t w);
        directed_words = {directed_words, w};
    endtask

    // zeros, extremes and unreduced values well above their share
    function automatic logic [29:0] pick_operand();
        logic [29:0] v;
        case ($urandom_range(11))
            0:       v = 30'd0;
            1:       v = RESIDUE_MAX;
            2:       v = MODULUS;
            3:       v = 30'($urandom_range(OPERAND_MAX, MODULUS));
            4:       v = 30'($urandom());
            5:       v = 30'($urandom_range(15));
            default: v = 30'($urandom_range(RESIDUE_MAX));
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_exponent();
        logic [31:0] e;
        case ($urandom_range(9))
            0:       e = 32'd0;
            1:       e = 32'hFFFF_FFFF;
            2:       e = $urandom_range(15);
            3:       e = $urandom_range(16'hFFFF);
            default: e = $urandom();
        endcase
        return e;
    endfunction

    function automatic logic [2:0] pick_command();
        logic [2:0] cmd;
        case ($urandom_range(19))
            0, 1, 2, 3:      cmd = CMD_ADD;
            4, 5, 6:         cmd = CMD_SUB;
            7, 8, 9:         cmd = CMD_MUL;
            10, 11, 12, 13:  cmd = CMD_POW;
            14, 15, 16, 17:  cmd = CMD_DIV;
            default:         cmd = 3'($urandom_range(CMD_LAST, CMD_FIRST_UNUSED));
        endcase
        return cmd;
    endfunction

    // hold the word up until the block takes it; start stays high afterwards
    task automatic issue_word(input pma_req_t w, input bit allow_idle);
        int idle;
        if (allow_idle && $urandom_range(3) == 0)
        begin
            idle = $urandom_range(18, 1);
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        start   <= 1'b1;
        request <= w;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    initial
    begin
        queue_directed(make_word(CMD_ADD, RESIDUE_MAX, RESIDUE_MAX, 32'd0));
        queue_directed(make_word(CMD_ADD, 30'd0, 30'd0, 32'hFFFF_FFFF));
        queue_directed(make_word(CMD_ADD, OPERAND_MAX, OPERAND_MAX, 32'd0));
        queue_directed(make_word(CMD_SUB, 30'd0, RESIDUE_MAX, 32'd0));
        queue_directed(make_word(CMD_SUB, RESIDUE_MAX, 30'd0, 32'd0));
        queue_directed(make_word(CMD_SUB, MODULUS, OPERAND_MAX, 32'd0));
        queue_directed(make_word(CMD_SUB, 30'd12345, 30'd12345, 32'd0));
        queue_directed(make_word(CMD_MUL, RESIDUE_MAX, RESIDUE_MAX, 32'd0));
        queue_directed(make_word(CMD_MUL, 30'd0, RESIDUE_MAX, 32'd0));
        queue_directed(make_word(CMD_MUL, OPERAND_MAX, OPERAND_MAX, 32'd0));
        // zero exponent gives one, base zero included
        queue_directed(make_word(CMD_POW, 30'd0, 30'd0, 32'd0));
        queue_directed(make_word(CMD_POW, RESIDUE_MAX, 30'd7, 32'd0));
        queue_directed(make_word(CMD_POW, 30'd0, 30'd0, 32'd5));
        queue_directed(make_word(CMD_POW, 30'd2, 30'd0, 32'd1));
        queue_directed(make_word(CMD_POW, RESIDUE_MAX, RESIDUE_MAX, 32'hFFFF_FFFF));
        queue_directed(make_word(CMD_POW, OPERAND_MAX, 30'd0, 32'h8000_0000));
        queue_directed(make_word(CMD_DIV, 30'd99, 30'd0, 32'd0));
        // divisor equal to the modulus reduces to zero
        queue_directed(make_word(CMD_DIV, RESIDUE_MAX, MODULUS, 32'd0));
        queue_directed(make_word(CMD_DIV, 30'd42, 30'd1, 32'd0));
        queue_directed(make_word(CMD_DIV, RESIDUE_MAX, RESIDUE_MAX, 32'hFFFF_FFFF));
        queue_directed(make_word(CMD_DIV, OPERAND_MAX, OPERAND_MAX, 32'd0));
        queue_directed(make_word(CMD_FIRST_UNUSED, RESIDUE_MAX, 30'd3, 32'd9));
        queue_directed(make_word(CMD_FIRST_UNUSED + 3'd1, 30'd1, 30'd0, 32'd2));
        queue_directed(make_word(CMD_LAST, OPERAND_MAX, OPERAND_MAX, 32'hFFFF_FFFF));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
        begin
            issue_word(directed_words[i], 1'b1);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // let the block empty out once mid-run before carrying on
            if (n == RANDOM_WORDS / 2)
            begin
                wait_until_drained();
            end
            issue_word(make_word(pick_command(), pick_operand(), pick_operand(),
                                 pick_exponent()),
                       n < RANDOM_WORDS - STEADY_TAIL);
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pma_pkg.sv
sv/pma_mulmod.sv
sv/prime_modular_alu.sv
test/pma_result_checker.sv
test/tb_prime_modular_alu.sv
